// ===== hdl/ogh_pkg.sv =====
package ogh_pkg;

  localparam int GRID_SIDE_DEF = 256;

  localparam int CELL_SHIFT_W = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CELL_SHIFT_W-1:0] CELL_SHIFT_RST  = 4'd8;
  localparam logic signed [15:0]      FLOOR_HEIGHT_RST = 16'sd0;
  localparam logic [15:0]             BASE_MARGIN_RST = 16'd200;
  localparam logic [15:0]             MIN_SPREAD_RST  = 16'd100;
  localparam logic [15:0]             MIN_POINTS_RST  = 16'd1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CELL_SHIFT   = 3'd0,
    CFG_FLOOR_HEIGHT = 3'd1,
    CFG_BASE_MARGIN  = 3'd2,
    CFG_MIN_SPREAD   = 3'd3,
    CFG_MIN_POINTS   = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] height_z;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
  } in_item_t;

  typedef struct packed {
    logic               wall_cell;
    logic [15:0]        point_count;
    logic signed [15:0] lowest_z;
    logic signed [15:0] highest_z;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        count;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } cell_t;

endpackage

// ===== hdl/ogh_ram.sv =====
module ogh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/occupancy_grid_height_binner.sv =====
// Bins points into a GRID_SIDE x GRID_SIDE height grid kept in one on-chip RAM and answers
// cell queries. Items pass a three-step pipeline (input register, RAM read, update/write-back
// with forwarding), so one item is accepted per clock unless stalled or clearing; a query
// result is registered onto out_item after the input register and RAM read stages. A query
// that finds the result register full and stalled freezes the pipeline. A clear item, and
// reset, start a clearing pass that writes one cell per cycle to all GRID_SIDE*GRID_SIDE
// cells (65536 by default), in_stall held high; configuration writes are taken throughout.
module occupancy_grid_height_binner #(
  parameter int GRID_SIDE = ogh_pkg::GRID_SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ogh_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ogh_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [ogh_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ogh_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import ogh_pkg::*;

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int HALF   = GRID_SIDE / 2;
  localparam int CELL_W = $bits(cell_t);

  logic [CELL_SHIFT_W-1:0] cell_shift_r;
  logic signed [15:0]      floor_height_r;
  logic [15:0]             base_margin_r;
  logic [15:0]             min_spread_r;
  logic [15:0]             min_points_r;

  logic                    s0_v_r;
  logic [1:0]              s0_act_r;
  logic signed [20:0]      s0_shx_r;
  logic signed [20:0]      s0_shy_r;
  logic signed [15:0]      s0_z_r;
  logic [7:0]              s0_col_r;
  logic [7:0]              s0_row_r;

  logic                    s1_v_r;
  logic [1:0]              s1_act_r;
  logic                    s1_hit_r;
  logic [ADDR_W-1:0]       s1_addr_r;
  logic signed [15:0]      s1_z_r;
  logic                    s1_fwd_r;
  cell_t                   s1_fwd_cell_r;

  logic                    sweep_r;
  logic [ADDR_W-1:0]       sweep_addr_r;
  logic                    clear_pend_r;

  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic                    adv;
  logic                    accept;
  logic signed [20:0]      mir_x;
  logic signed [20:0]      mir_y;
  logic signed [20:0]      sh_x;
  logic signed [20:0]      sh_y;

  logic                    rd_hit;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    fwd_nxt;

  logic [CELL_W-1:0]       ram_rdata;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [CELL_W-1:0]       ram_wdata;

  cell_t                   cur;
  cell_t                   upd;
  logic                    wr;
  out_item_t               res;

  assign adv = !sweep_r &&
               !(s1_v_r && s1_act_r == ACT_QUERY && out_valid_r && out_stall);
  assign in_stall = !adv || clear_pend_r;
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_shift_r   <= CELL_SHIFT_RST;
      floor_height_r <= FLOOR_HEIGHT_RST;
      base_margin_r  <= BASE_MARGIN_RST;
      min_spread_r   <= MIN_SPREAD_RST;
      min_points_r   <= MIN_POINTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_SHIFT:   cell_shift_r   <= cfg_wdata[CELL_SHIFT_W-1:0];
        CFG_FLOOR_HEIGHT: floor_height_r <= $signed(cfg_wdata);
        CFG_BASE_MARGIN:  base_margin_r  <= cfg_wdata;
        CFG_MIN_SPREAD:   min_spread_r   <= cfg_wdata;
        CFG_MIN_POINTS:   min_points_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // mirror and scale to cell units
  assign mir_x = -$signed({in_item.pos_x[19], in_item.pos_x});
  assign mir_y = -$signed({in_item.pos_y[19], in_item.pos_y});
  assign sh_x  = mir_x >>> cell_shift_r;
  assign sh_y  = mir_y >>> cell_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_act_r <= in_item.action;
      s0_shx_r <= sh_x;
      s0_shy_r <= sh_y;
      s0_z_r   <= in_item.height_z;
      s0_col_r <= in_item.cell_col;
      s0_row_r <= in_item.cell_row;
    end
  end

  always_comb begin
    logic signed [21:0] col_w;
    logic signed [21:0] row_w;
    logic               add_ok;
    logic               qry_ok;
    logic [IDX_W-1:0]   col_i;
    logic [IDX_W-1:0]   row_i;
    col_w  = $signed({s0_shx_r[20], s0_shx_r}) + $signed(22'(HALF));
    row_w  = $signed({s0_shy_r[20], s0_shy_r}) + $signed(22'(HALF));
    add_ok = !col_w[21] && (col_w < $signed(22'(GRID_SIDE))) &&
             !row_w[21] && (row_w < $signed(22'(GRID_SIDE)));
    qry_ok = (32'(s0_col_r) < 32'(GRID_SIDE)) && (32'(s0_row_r) < 32'(GRID_SIDE));
    if (s0_act_r == ACT_ADD) begin
      rd_hit = add_ok;
      col_i  = col_w[IDX_W-1:0];
      row_i  = row_w[IDX_W-1:0];
    end else begin
      rd_hit = qry_ok && s0_act_r == ACT_QUERY;
      col_i  = IDX_W'(s0_col_r);
      row_i  = IDX_W'(s0_row_r);
    end
    if (rd_hit) begin
      rd_addr = ADDR_W'(32'(col_i) * 32'(GRID_SIDE) + 32'(row_i));
    end else begin
      rd_addr = '0;
    end
  end

  assign fwd_nxt = wr && s0_v_r && rd_hit && rd_addr == s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act_r      <= s0_act_r;
      s1_hit_r      <= rd_hit;
      s1_addr_r     <= rd_addr;
      s1_z_r        <= s0_z_r;
      s1_fwd_r      <= fwd_nxt;
      s1_fwd_cell_r <= upd;
    end
  end

  ogh_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv && s0_v_r),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur = s1_fwd_r ? s1_fwd_cell_r : cell_t'(ram_rdata);
    upd = cur;
    if (cur.count == '0) begin
      upd.lo = s1_z_r;
      upd.hi = s1_z_r;
    end else begin
      if (s1_z_r < cur.lo) begin
        upd.lo = s1_z_r;
      end
      if (s1_z_r > cur.hi) begin
        upd.hi = s1_z_r;
      end
    end
    if (cur.count != COUNT_MAX) begin
      upd.count = cur.count + 16'd1;
    end
  end

  assign wr = adv && s1_v_r && s1_act_r == ACT_ADD && s1_hit_r;

  assign ram_we    = sweep_r || wr;
  assign ram_waddr = sweep_r ? sweep_addr_r : s1_addr_r;
  assign ram_wdata = sweep_r ? '0 : CELL_W'(upd);

  always_comb begin
    logic               filled;
    logic signed [17:0] lo_lim;
    logic signed [16:0] spread;
    res.point_count = s1_hit_r ? cur.count : '0;
    filled          = res.point_count != '0;
    res.lowest_z    = filled ? cur.lo : '0;
    res.highest_z   = filled ? cur.hi : '0;
    lo_lim = $signed({{2{floor_height_r[15]}}, floor_height_r}) +
             $signed({2'b00, base_margin_r});
    spread = $signed({res.highest_z[15], res.highest_z}) -
             $signed({res.lowest_z[15], res.lowest_z});
    res.wall_cell = filled &&
                    ($signed({{2{res.lowest_z[15]}}, res.lowest_z}) <= lo_lim) &&
                    (spread >= $signed({1'b0, min_spread_r})) &&
                    (res.point_count >= min_points_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_v_r && s1_act_r == ACT_QUERY) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r && s1_act_r == ACT_QUERY) begin
      out_item_r <= res;
    end
  end

  // hold input from a clear until its sweep ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
      clear_pend_r <= 1'b0;
    end else begin
      if (accept && in_item.action == ACT_CLEAR) begin
        clear_pend_r <= 1'b1;
      end
      if (sweep_r) begin
        if (sweep_addr_r == ADDR_W'(DEPTH - 1)) begin
          sweep_r      <= 1'b0;
          clear_pend_r <= 1'b0;
        end
        sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
      end else if (adv && s1_v_r && s1_act_r == ACT_CLEAR) begin
        sweep_r      <= 1'b1;
        sweep_addr_r <= '0;
      end
    end
  end

endmodule
